// ===== hw/rtl/rgpg_pkg.sv =====
`timescale 1ns / 1ps
package rgpg_pkg;

  // Field widths are fixed by the register map and the sample format
  localparam int SAMPLE_BITS  = 16;
  localparam int PHASE_BITS   = 16;
  localparam int CFG_IDX_BITS = 3;

  // Shutter window and pulse train
  localparam int GUARD_GAP  = 50;
  localparam int PULSE_STEP = 10;
  localparam int PULSE_ON   = 7;

  // floor(x / 10) == (x * 52429) >> 19 for every 16-bit x
  localparam int RECIP_10    = 52429;
  localparam int RECIP_SHIFT = 19;
  localparam int RECIP_BITS  = PHASE_BITS + 17;
  localparam int QUOT10_BITS = 13;

  // Serial divider: one quotient bit per cycle over the full product
  localparam int PROD_BITS = 2 * SAMPLE_BITS;
  localparam int DIV_STEPS = PROD_BITS;
  localparam int CNT_BITS  = $clog2(DIV_STEPS);

  // Register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LOW_LEVEL  = 3'd0,
    REG_HIGH_LEVEL = 3'd1,
    REG_RISE_START = 3'd2,
    REG_PEAK_AT    = 3'd3,
    REG_PERIOD     = 3'd4
  } reg_idx_t;

  // Reset values of the registers
  localparam logic [15:0] RST_LOW_LEVEL  = 16'd3277;
  localparam logic [15:0] RST_HIGH_LEVEL = 16'd32767;
  localparam logic [15:0] RST_RISE_START = 16'd200;
  localparam logic [15:0] RST_PEAK_AT    = 16'd900;
  localparam logic [15:0] RST_PERIOD     = 16'd1000;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] low_level;
    logic signed [SAMPLE_BITS-1:0] high_level;
    logic [PHASE_BITS-1:0]         rise_start;
    logic [PHASE_BITS-1:0]         peak_at;
    logic [PHASE_BITS-1:0]         period;
  } cfg_t;

  // Sequencer commands to the datapath
  typedef struct packed {
    logic capture;
    logic setup;
    logic absolute;
    logic multiply;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SETUP = 6'b000010,
    ST_ABS   = 6'b000100,
    ST_MUL   = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

endpackage

// ===== hw/rtl/rgpg_regs.sv =====
`timescale 1ns / 1ps
module rgpg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rgpg_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [15:0]                         cfg_data,
  output rgpg_pkg::cfg_t                      cfg
);
  import rgpg_pkg::*;

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register file, unused indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_level  <= RST_LOW_LEVEL;
      cfg.high_level <= RST_HIGH_LEVEL;
      cfg.rise_start <= RST_RISE_START;
      cfg.peak_at    <= RST_PEAK_AT;
      cfg.period     <= RST_PERIOD;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LOW_LEVEL:  cfg.low_level  <= cfg_data;
        REG_HIGH_LEVEL: cfg.high_level <= cfg_data;
        REG_RISE_START: cfg.rise_start <= cfg_data;
        REG_PEAK_AT:    cfg.peak_at    <= cfg_data;
        REG_PERIOD:     cfg.period     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/rgpg_ctrl.sv =====
`timescale 1ns / 1ps
module rgpg_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output rgpg_pkg::cmd_t cmd
);
  import rgpg_pkg::*;

  state_t              state, state_next;
  logic [CNT_BITS-1:0] cnt;
  logic                slot_free;

  assign in_ready  = (state == ST_IDLE);
  assign slot_free = !out_valid || out_ready;

  // command decode
  always_comb begin
    cmd          = '0;
    cmd.capture  = (state == ST_IDLE) && in_valid;
    cmd.setup    = (state == ST_SETUP);
    cmd.absolute = (state == ST_ABS);
    cmd.multiply = (state == ST_MUL);
    cmd.div_step = (state == ST_DIV);
    cmd.emit     = (state == ST_DONE) && slot_free;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_SETUP;
      ST_SETUP: state_next = ST_ABS;
      ST_ABS:   state_next = ST_MUL;
      ST_MUL:   state_next = ST_DIV;
      ST_DIV:   if (cnt == CNT_BITS'(DIV_STEPS - 1)) state_next = ST_DONE;
      ST_DONE:  if (slot_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // divider step count
      if (cmd.multiply) cnt <= '0;
      else if (cmd.div_step) cnt <= cnt + 1'b1;
      // output slot
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/rgpg_dp.sv =====
`timescale 1ns / 1ps
module rgpg_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  rgpg_pkg::cfg_t                      cfg,
  input  rgpg_pkg::cmd_t                      cmd,
  input  logic                                restart,
  output logic signed [rgpg_pkg::SAMPLE_BITS-1:0] level,
  output logic                                shutter_on,
  output logic [rgpg_pkg::PHASE_BITS-1:0]     phase_index
);
  import rgpg_pkg::*;

  localparam int DB = SAMPLE_BITS + 1;

  logic [PHASE_BITS-1:0]         phase_count;
  logic [PHASE_BITS-1:0]         ph;
  logic [PHASE_BITS-1:0]         phase_sel;
  logic [PHASE_BITS:0]           ph_inc;
  logic signed [DB-1:0]          diff;
  logic signed [SAMPLE_BITS-1:0] base;
  logic [PHASE_BITS-1:0]         off;
  logic [PHASE_BITS-1:0]         len;
  logic                          win;
  logic [PHASE_BITS-1:0]         xm;
  logic                          neg;
  logic [SAMPLE_BITS-1:0]        mag;
  logic [RECIP_BITS-1:0]         recip;
  logic [QUOT10_BITS-1:0]        quot10;
  logic [PHASE_BITS-1:0]         rem10;
  logic                          shut;
  logic [PROD_BITS-1:0]          dq;
  logic [PHASE_BITS-1:0]         rem;
  logic [PHASE_BITS:0]           rem_sh;
  logic [DB-1:0]                 qs;
  logic [DB-1:0]                 sum;

  assign phase_sel = restart ? '0 : phase_count;
  assign ph_inc    = {1'b0, ph} + 1'b1;
  assign quot10    = recip[RECIP_SHIFT +: QUOT10_BITS];
  assign rem10     = xm - PHASE_BITS'(quot10 * PULSE_STEP);
  assign rem_sh    = {rem, dq[PROD_BITS-1]};
  assign qs        = {1'b0, dq[SAMPLE_BITS-1:0]};
  assign sum       = {base[SAMPLE_BITS-1], base} + (neg ? -qs : qs);

  // phase counter
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count <= '0;
    end else if (cmd.setup) begin
      phase_count <= (ph_inc >= {1'b0, cfg.period}) ? '0 : ph_inc[PHASE_BITS-1:0];
    end
  end

  // sample phase, out-of-range phase falls back to zero
  always_ff @(posedge clk) begin
    if (cmd.capture) ph <= (phase_sel >= cfg.period) ? '0 : phase_sel;
  end

  // segment select: operands of the ramp and the shutter window
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      if (ph < cfg.rise_start) begin
        diff <= '0;
        base <= cfg.low_level;
        off  <= '0;
        len  <= PHASE_BITS'(1);
      end else if (ph < cfg.peak_at) begin
        diff <= {cfg.high_level[SAMPLE_BITS-1], cfg.high_level}
              - {cfg.low_level[SAMPLE_BITS-1], cfg.low_level};
        base <= cfg.low_level;
        off  <= ph - cfg.rise_start;
        len  <= cfg.peak_at - cfg.rise_start;
      end else begin
        diff <= {cfg.low_level[SAMPLE_BITS-1], cfg.low_level}
              - {cfg.high_level[SAMPLE_BITS-1], cfg.high_level};
        base <= cfg.high_level;
        off  <= ph - cfg.peak_at;
        len  <= cfg.period - cfg.peak_at;
      end
      win <= ({1'b0, ph} >= ({1'b0, cfg.rise_start} + (PHASE_BITS+1)'(GUARD_GAP)))
          && (({1'b0, ph} + (PHASE_BITS+1)'(GUARD_GAP)) < {1'b0, cfg.peak_at});
      xm  <= ph - PHASE_BITS'(GUARD_GAP);
    end
  end

  // sign and magnitude of the level step; reciprocal product for mod 10
  always_ff @(posedge clk) begin
    if (cmd.absolute) begin
      neg   <= diff[DB-1];
      mag   <= diff[DB-1] ? SAMPLE_BITS'(-diff) : diff[SAMPLE_BITS-1:0];
      recip <= RECIP_BITS'(xm) * RECIP_BITS'(RECIP_10);
    end
  end

  // product into the divider, shutter decision
  always_ff @(posedge clk) begin
    if (cmd.multiply) begin
      shut <= win && (rem10 < PHASE_BITS'(PULSE_ON));
    end
  end

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.multiply) begin
      dq  <= PROD_BITS'(mag) * PROD_BITS'(off);
      rem <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, len}) begin
        rem <= PHASE_BITS'(rem_sh - {1'b0, len});
        dq  <= {dq[PROD_BITS-2:0], 1'b1};
      end else begin
        rem <= rem_sh[PHASE_BITS-1:0];
        dq  <= {dq[PROD_BITS-2:0], 1'b0};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      level       <= sum[SAMPLE_BITS-1:0];
      shutter_on  <= shut;
      phase_index <= ph;
    end
  end

endmodule

// ===== hw/rtl/ramp_and_gated_pulse_generator.sv =====
`timescale 1ns / 1ps
// From the accepting edge to out_valid a sample passes setup, sign, multiply,
// 32 divider steps and the output load; the 32-step serial divider is the bulk.
// One sample at a time; a new request is taken after the output load. A finished
// result waits in the output register and stalls only the final load.
// Reset (rst, synchronous, active high): phase zero, registers to defaults,
// no result pending, ready for a request in the next cycle.
module ramp_and_gated_pulse_generator (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    restart,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [rgpg_pkg::SAMPLE_BITS-1:0] level,
  output logic                                    shutter_on,
  output logic [rgpg_pkg::PHASE_BITS-1:0]         phase_index,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [rgpg_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [15:0]                             cfg_data
);
  import rgpg_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  rgpg_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rgpg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  rgpg_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .restart     (restart),
    .level       (level),
    .shutter_on  (shutter_on),
    .phase_index (phase_index)
  );

`ifndef NO_ASSERTIONS
  // one sample in flight: a new request is refused straight after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while a sample is in progress");

  // a pending sample carries a phase inside the period
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (phase_index < cfg.period || phase_index == '0))
    else $error("phase outside the period");

  // the shutter only opens past the guard gap after the rise start
  a_shutter_window: assert property (@(posedge clk) disable iff (rst)
    (out_valid && shutter_on) |->
      ({1'b0, phase_index} >= ({1'b0, cfg.rise_start} + (PHASE_BITS+1)'(GUARD_GAP))))
    else $error("shutter open outside its window");
`endif

endmodule
